FILE: design/bpc_pkg.sv
package bpc_pkg;

    localparam int BUTTONS_DEFAULT    = 8;
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int THRESH_W           = 16;
    localparam int ACTION_W           = 2;
    localparam int CFG_INDEX_W        = 1;

    localparam logic [ACTION_W-1:0] ACT_PRESS   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_PRESS = 1'b1;

    localparam logic [THRESH_W-1:0] LONG_PRESS_RESET  = 16'd100;
    localparam logic [THRESH_W-1:0] SHORT_PRESS_RESET = 16'd5;

endpackage

FILE: design/button_press_classifier.sv
// Classifies presses on up to BUTTONS debounced buttons. Press and release
// transactions set or clear bits of the held set; a tick transaction advances
// one saturating counter per held button, in parallel lanes, and yields one
// result: a long-press bit for each counter that passed long_press_ticks (the
// counter then reloads to half that value, which gives autorepeat) and a
// short-press bit for each button released since the previous tick whose
// count lay strictly between short_press_ticks and long_press_ticks. One
// transaction is accepted each cycle while in_stall is low; a tick result is
// registered at the output, or in the skid entry while the output stalls. A
// two-entry output buffer absorbs downstream stalls, and in_stall rises only
// while both entries are occupied. Configuration writes are taken at once.
module button_press_classifier #(
    parameter int BUTTONS    = bpc_pkg::BUTTONS_DEFAULT,
    parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bpc_pkg::ACTION_W-1:0]    action,
    input  logic [BUTTONS-1:0]              change_mask,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [BUTTONS-1:0]              long_press,
    output logic [BUTTONS-1:0]              short_press,
    input  logic                            cfg_we,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bpc_pkg::THRESH_W-1:0]    cfg_data
);
    import bpc_pkg::*;

    logic [THRESH_W-1:0] long_ticks_reg;
    logic [THRESH_W-1:0] short_ticks_reg;
    logic [BUTTONS-1:0]  held_reg;
    logic [BUTTONS-1:0]  held_next;
    logic [BUTTONS-1:0]  prior_reg;
    logic [BUTTONS-1:0]  prior_next;
    logic [BUTTONS-1:0]  gone;
    logic [BUTTONS-1:0]  lane_long;
    logic [BUTTONS-1:0]  lane_short;
    logic                accept;
    logic                tick;
    logic                buf_full;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;
    assign tick     = accept && (action == ACT_TICK);
    assign gone     = prior_reg & ~held_reg;

    always_comb
    begin
        held_next  = held_reg;
        prior_next = prior_reg;
        if (accept)
        begin
            case (action)
                ACT_PRESS:   held_next  = held_reg | change_mask;
                ACT_RELEASE: held_next  = held_reg & ~change_mask;
                ACT_TICK:    prior_next = held_reg;
                default:     held_next  = held_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= '0;
            prior_reg       <= '0;
            long_ticks_reg  <= LONG_PRESS_RESET;
            short_ticks_reg <= SHORT_PRESS_RESET;
        end
        else
        begin
            held_reg  <= held_next;
            prior_reg <= prior_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LONG_PRESS:  long_ticks_reg  <= cfg_data;
                    REG_SHORT_PRESS: short_ticks_reg <= cfg_data;
                    default:         long_ticks_reg  <= long_ticks_reg;
                endcase
            end
        end
    end

    for (genvar b = 0; b < BUTTONS; b++)
    begin : g_lane
        bpc_lane #(
            .COUNT_BITS(COUNT_BITS)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .tick       (tick),
            .held       (held_reg[b]),
            .gone       (gone[b]),
            .long_ticks (long_ticks_reg),
            .short_ticks(short_ticks_reg),
            .long_hit   (lane_long[b]),
            .short_hit  (lane_short[b])
        );
    end

    bpc_outbuf #(
        .BUTTONS(BUTTONS)
    ) u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .produce    (tick),
        .lane_long  (lane_long),
        .lane_short (lane_short),
        .full       (buf_full),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .long_press (long_press),
        .short_press(short_press)
    );

endmodule

FILE: design/bpc_lane.sv
module bpc_lane #(
    parameter int COUNT_BITS = bpc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick,
    input  logic                          held,
    input  logic                          gone,
    input  logic [bpc_pkg::THRESH_W-1:0]  long_ticks,
    input  logic [bpc_pkg::THRESH_W-1:0]  short_ticks,
    output logic                          long_hit,
    output logic                          short_hit
);
    import bpc_pkg::*;

    localparam int CMP_W = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic [COUNT_BITS-1:0] reload;
    logic [CMP_W-1:0]      inc_wide;
    logic [CMP_W-1:0]      cur_wide;
    logic [CMP_W-1:0]      long_wide;
    logic [CMP_W-1:0]      short_wide;
    logic [CMP_W-1:0]      half_wide;

    always_comb
    begin
        // saturating increment
        count_inc  = (count_reg == {COUNT_BITS{1'b1}}) ? count_reg : count_reg + 1'b1;
        inc_wide   = CMP_W'(count_inc);
        cur_wide   = CMP_W'(count_reg);
        long_wide  = CMP_W'(long_ticks);
        short_wide = CMP_W'(short_ticks);
        half_wide  = CMP_W'(long_ticks >> 1);
        reload     = half_wide[COUNT_BITS-1:0];

        long_hit   = held && (inc_wide > long_wide);
        // a released button is never held, so its count is still the stored one
        short_hit  = gone && (cur_wide > short_wide) && (cur_wide < long_wide);

        count_next = count_reg;
        if (tick)
        begin
            if (held)
            begin
                count_next = long_hit ? reload : count_inc;
            end
            else if (gone)
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/bpc_outbuf.sv
module bpc_outbuf #(
    parameter int BUTTONS = bpc_pkg::BUTTONS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               produce,
    input  logic [BUTTONS-1:0] lane_long,
    input  logic [BUTTONS-1:0] lane_short,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [BUTTONS-1:0] long_press,
    output logic [BUTTONS-1:0] short_press
);
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BUTTONS-1:0] out_long_reg;
    logic [BUTTONS-1:0] out_long_next;
    logic [BUTTONS-1:0] out_short_reg;
    logic [BUTTONS-1:0] out_short_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    logic [BUTTONS-1:0] skid_long_reg;
    logic [BUTTONS-1:0] skid_long_next;
    logic [BUTTONS-1:0] skid_short_reg;
    logic [BUTTONS-1:0] skid_short_next;
    logic               out_free;

    always_comb
    begin
        out_free        = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg;
        out_long_next   = out_long_reg;
        out_short_next  = out_short_reg;
        skid_valid_next = skid_valid_reg;
        skid_long_next  = skid_long_reg;
        skid_short_next = skid_short_reg;

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_long_next   = skid_long_reg;
                out_short_next  = skid_short_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = produce;
                out_long_next  = lane_long;
                out_short_next = lane_short;
            end
        end
        else if (produce)
        begin
            // output is stalled, park the new transaction
            skid_valid_next = 1'b1;
            skid_long_next  = lane_long;
            skid_short_next = lane_short;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_long_reg   <= out_long_next;
        out_short_reg  <= out_short_next;
        skid_long_reg  <= skid_long_next;
        skid_short_reg <= skid_short_next;
    end

    assign full        = skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign long_press  = out_long_reg;
    assign short_press = out_short_reg;

endmodule

FILE: verif/button_press_classifier_test.sv
`timescale 1ns / 100ps

module button_press_classifier_test;

    import bpc_pkg::*;

    localparam int NB = BUTTONS_DEFAULT;
    localparam int CB = COUNT_BITS_DEFAULT;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int STALL_PCT = 21;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;

    typedef logic [NB-1:0] mask_t;
    typedef logic [CB-1:0] count_t;

    typedef struct packed {
        mask_t long_bits;
        mask_t short_bits;
    } press_flags_t;

    class press_scoreboard;
        logic [THRESH_W-1:0] long_ticks;
        logic [THRESH_W-1:0] short_ticks;
        mask_t held;
        mask_t held_at_tick;
        count_t counts [NB];
        press_flags_t flags_q [$];
        int errors;

        function new();
            long_ticks = LONG_PRESS_RESET;
            short_ticks = SHORT_PRESS_RESET;
            held = '0;
            held_at_tick = '0;
            foreach (counts[b])
                counts[b] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [THRESH_W-1:0] data);
            if (idx == REG_LONG_PRESS)
                long_ticks = data;
            else
                short_ticks = data;
        endfunction

        function void note_input(logic [ACTION_W-1:0] act, mask_t mask);
            press_flags_t flags;
            mask_t released;
            flags = '0;
            case (act)
                ACT_PRESS: held = held | mask;
                ACT_RELEASE: held = held & ~mask;
                ACT_TICK:
                begin
                    for (int b = 0; b < NB; b++)
                    begin
                        if (held[b])
                        begin
                            if (counts[b] != {CB{1'b1}})
                                counts[b] = counts[b] + 1'b1;
                            // past the threshold: flag it and reload for autorepeat
                            if (counts[b] > long_ticks)
                            begin
                                flags.long_bits[b] = 1'b1;
                                counts[b] = count_t'(long_ticks >> 1);
                            end
                        end
                    end
                    released = held_at_tick & ~held;
                    held_at_tick = held;
                    for (int b = 0; b < NB; b++)
                    begin
                        if (released[b])
                        begin
                            if (counts[b] > short_ticks && counts[b] < long_ticks)
                                flags.short_bits[b] = 1'b1;
                            counts[b] = '0;
                        end
                    end
                    flags_q.push_back(flags);
                end
                default: ;
            endcase
        endfunction

        function void check_result(mask_t long_bits, mask_t short_bits);
            press_flags_t want;
            if (flags_q.size() == 0)
            begin
                $error("unexpected transaction: long_press=%h short_press=%h",
                       long_bits, short_bits);
                errors++;
                return;
            end
            want = flags_q.pop_front();
            if (long_bits !== want.long_bits)
            begin
                $error("long_press: expected %h, actual %h", want.long_bits, long_bits);
                errors++;
            end
            if (short_bits !== want.short_bits)
            begin
                $error("short_press: expected %h, actual %h", want.short_bits, short_bits);
                errors++;
            end
        endfunction

        function int pending();
            return flags_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [ACTION_W-1:0]    action;
    mask_t                  change_mask;
    logic                   out_valid;
    logic                   out_stall;
    mask_t                  long_press;
    mask_t                  short_press;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [THRESH_W-1:0]    cfg_data;

    press_scoreboard sb;
    bit calm;
    bit hold_off_req;

    button_press_classifier u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .change_mask(change_mask),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .long_press (long_press),
        .short_press(short_press),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(action, change_mask);
            if (out_valid && !out_stall)
                sb.check_result(long_press, short_press);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // downstream side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < STALL_PCT);
        end
    end

    function automatic int idle_gap();
        if (calm || $urandom_range(99) >= STALL_PCT)
            return 0;
        return $urandom_range(1, 5);
    endfunction

    function automatic mask_t pick_mask();
        if ($urandom_range(1) == 0)
            return mask_t'(1) << $urandom_range(NB - 1);
        return mask_t'($urandom);
    endfunction

    // called and returns at a falling edge
    task automatic send_item(input logic [ACTION_W-1:0] act, input mask_t mask);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            action <= ACTION_W'($urandom);
            change_mask <= mask_t'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        change_mask <= mask;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_thresholds(input logic [THRESH_W-1:0] long_val,
                                    input logic [THRESH_W-1:0] short_val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_LONG_PRESS;
        cfg_data <= long_val;
        sb.write_reg(REG_LONG_PRESS, long_val);
        @(negedge clk);
        cfg_index <= REG_SHORT_PRESS;
        cfg_data <= short_val;
        sb.write_reg(REG_SHORT_PRESS, short_val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly press / hold for some ticks / release sequences, some noise
    task automatic run_random(input int n_items);
        int sent;
        int ticks;
        int lim;
        mask_t m;
        logic [ACTION_W-1:0] act;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 70)
            begin
                m = pick_mask();
                send_item(ACT_PRESS, m);
                lim = (sb.long_ticks + 3 > 24) ? 24 : sb.long_ticks + 3;
                ticks = $urandom_range(0, lim);
                repeat (ticks) send_item(ACT_TICK, mask_t'($urandom));
                if ($urandom_range(1) == 0)
                    send_item(ACT_RELEASE, m);
                else
                    send_item(ACT_RELEASE, m & mask_t'($urandom));
                sent += ticks + 2;
                ticks = $urandom_range(0, 3);
                repeat (ticks) send_item(ACT_TICK, mask_t'($urandom));
                sent += ticks;
            end
            else
            begin
                act = ACTION_W'($urandom_range(0, 3));
                send_item(act, mask_t'($urandom));
                if (act != ACT_UNUSED)
                    sent++;
            end
        end
    endtask

    initial
    begin
        logic [THRESH_W-1:0] long_set [9];
        logic [THRESH_W-1:0] short_set [9];
        long_set  = '{16'd6, 16'd2, 16'd1, 16'd0, 16'd12, 16'd65535, 16'd3, 16'd20, 16'd100};
        short_set = '{16'd2, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd1, 16'd7, 16'd5};

        sb = new();
        calm = 1'b0;
        hold_off_req = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_PRESS;
        change_mask = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_LONG_PRESS;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset thresholds, mask extremes, unused action code
        send_item(ACT_PRESS, '1);
        send_item(ACT_TICK, '0);
        send_item(ACT_UNUSED, '1);
        send_item(ACT_RELEASE, '0);
        send_item(ACT_RELEASE, '1);
        send_item(ACT_TICK, '1);

        apply_thresholds(16'd4, 16'd1);
        // short press on button 0
        send_item(ACT_PRESS, 8'h01);
        repeat (3) send_item(ACT_TICK, '0);
        send_item(ACT_RELEASE, 8'h01);
        send_item(ACT_TICK, '0);
        // long press on button 1, then press and release inside one tick gap
        send_item(ACT_PRESS, 8'h02);
        repeat (5) send_item(ACT_TICK, '0);
        send_item(ACT_RELEASE, 8'h02);
        send_item(ACT_PRESS, 8'h04);
        send_item(ACT_RELEASE, 8'h04);
        send_item(ACT_TICK, '0);
        // release then re-press between ticks keeps the button held
        send_item(ACT_PRESS, 8'h80);
        repeat (2) send_item(ACT_TICK, '0);
        send_item(ACT_RELEASE, 8'h80);
        send_item(ACT_PRESS, 8'h80);
        send_item(ACT_TICK, '0);
        send_item(ACT_RELEASE, '1);
        send_item(ACT_TICK, '0);

        for (int p = 0; p < 10; p++)
        begin
            if (p < 9)
                apply_thresholds(long_set[p], short_set[p]);
            else
                apply_thresholds(THRESH_W'($urandom_range(2, 30)),
                                 THRESH_W'($urandom_range(0, 30)));
            if (p == 4)
            begin
                // no idling here, and the receiver holds off long enough to back up the input
                calm = 1'b1;
                hold_off_req = 1'b1;
            end
            run_random(45);
            calm = 1'b0;
        end

        // a threshold at the counter maximum never fires
        apply_thresholds(16'hFFFF, 16'hFFFE);
        send_item(ACT_PRESS, 8'h81);
        repeat (20) send_item(ACT_TICK, mask_t'($urandom));
        send_item(ACT_RELEASE, 8'h81);
        repeat (2) send_item(ACT_TICK, '0);

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: button_press_classifier.f
design/bpc_pkg.sv
design/bpc_lane.sv
design/bpc_outbuf.sv
design/button_press_classifier.sv
verif/button_press_classifier_test.sv
